// ----- design/frame_rate_index_mapper_assert.svh -----
// Assertion macros for the frame rate index mapper.
`ifndef FRAME_RATE_INDEX_MAPPER_ASSERT_SVH
`define FRAME_RATE_INDEX_MAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRIM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frim assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FRIM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frim assertion failed");

`endif

// ----- design/frim_pkg.sv -----
// Shared constants and types for the frame rate index mapper.
`default_nettype none
package frim_pkg;

	localparam int FRAME_W    = 31;
	localparam int RATIO_W    = 32;
	localparam int PROD_W     = FRAME_W + RATIO_W;
	localparam int LAST_W     = FRAME_W + 1;
	localparam int GAP_W      = FRAME_W + 2;
	localparam int MAX_GAP    = 10;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RATIO_W;

	localparam logic [FRAME_W-1:0] SRC_MAX = {FRAME_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_DEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_MODE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_EMIT  = 5'b10000
	} frim_state_t;

	typedef struct packed {
		logic               start;
		logic [PROD_W-1:0]  dividend;
		logic [RATIO_W-1:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [FRAME_W-1:0] quot;
	} div_stat_t;

endpackage
`default_nettype wire

// ----- design/frim_req_if.sv -----
// Request channel carrying one target frame number per item.
`default_nettype none
interface frim_req_if;
	import frim_pkg::*;

	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] target_frame;

	modport source (output valid, output target_frame, input ready);
	modport sink (input valid, input target_frame, output ready);
endinterface
`default_nettype wire

// ----- design/frim_fetch_if.sv -----
// Fetch channel carrying one source frame request per item.
`default_nettype none
interface frim_fetch_if;
	import frim_pkg::*;

	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] source_frame;
	logic               is_prefetch;
	logic               last_of_run;

	modport source (output valid, output source_frame, output is_prefetch,
		output last_of_run, input ready);
	modport sink (input valid, input source_frame, input is_prefetch,
		input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- design/frim_div.sv -----
// Restoring divider, one quotient bit per cycle, with saturation to the frame range.
`default_nettype none
module frim_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire frim_pkg::div_ctl_t ctl,
	output frim_pkg::div_stat_t     stat
);
	import frim_pkg::*;

	logic [PROD_W-1:0]    dvd_q;
	logic [RATIO_W-1:0]   rem_q;
	logic [FRAME_W-1:0]   quo_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [RATIO_W:0] shifted;
	logic [RATIO_W:0] diff;
	logic             take;

	assign shifted = {rem_q, dvd_q[PROD_W-1]};
	assign diff    = shifted - {1'b0, ctl.divisor};
	assign take    = shifted >= {1'b0, ctl.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= ctl.dividend;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			rem_q <= take ? diff[RATIO_W-1:0] : shifted[RATIO_W-1:0];
			// Any quotient bit pushed past the frame range means saturation.
			ovf_q <= ovf_q | quo_q[FRAME_W-1];
			quo_q <= {quo_q[FRAME_W-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = ovf_q ? SRC_MAX : quo_q;

endmodule
`default_nettype wire

// ----- design/frame_rate_index_mapper.sv -----
// Top level of the frame rate index mapper: sequencer, registers and output stage.
//
// Usage: each item on req carries a target frame number n. The block maps it to
// source frame floor(n * ratio_num / ratio_den), saturated to 2^31-1, and sends
// one or more items on fetch. In linear mode, when the new source frame lies 2 to
// 9 frames past the last fetched one, the skipped frames go out first, marked
// is_prefetch, in ascending order; the real fetch always ends the run and has
// last_of_run set.
// Timing: req.ready is high only while the sequencer is idle. An item passes
// a multiply state, 63 divider steps (one quotient bit per cycle in the
// restoring divider), a check state and the emit state, which loads each
// fetch of the run into the output register as a slot frees; the next
// request is taken the cycle after the real fetch is loaded there.
// A stalled receiver holds the output register and pauses the run; the last
// fetch of a run may wait there while the next request is already accepted.
// Reset sets ratio 1/1, linear mode on and the last fetched frame to -1.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
`default_nettype none
`include "frame_rate_index_mapper_assert.svh"
module frame_rate_index_mapper (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	frim_req_if.sink                           req,
	frim_fetch_if.source                       fetch,
	input  wire logic                          cfg_we,
	input  wire logic [frim_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [frim_pkg::CFG_DATA_W-1:0] cfg_data
);
	import frim_pkg::*;

	frim_state_t state_q;

	logic [RATIO_W-1:0] num_q;
	logic [RATIO_W-1:0] den_q;
	logic               linear_q;
	logic [LAST_W-1:0]  last_q;
	logic [FRAME_W-1:0] target_q;
	logic [FRAME_W-1:0] src_q;
	logic [FRAME_W-1:0] cur_q;

	logic               out_valid_q;
	logic [FRAME_W-1:0] out_src_q;
	logic               out_pre_q;
	logic               out_last_q;

	div_ctl_t  div_ctl;
	div_stat_t div_stat;

	logic                    accept;
	logic                    slot_free;
	logic                    emit_fire;
	logic                    at_end;
	logic signed [GAP_W-1:0] gap;
	logic                    do_prefetch;
	logic [LAST_W-1:0]       last_inc;

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || fetch.ready;
	assign emit_fire = (state_q == ST_EMIT) && slot_free;
	assign at_end    = (cur_q == src_q);

	assign gap = $signed({2'b00, src_q}) - $signed({last_q[LAST_W-1], last_q});
	assign do_prefetch = linear_q && (gap >= GAP_W'(2)) && (gap < GAP_W'(MAX_GAP));
	assign last_inc = last_q + LAST_W'(1);

	// The product is registered by the divider when it starts.
	assign div_ctl.start    = (state_q == ST_MUL);
	assign div_ctl.dividend = PROD_W'(target_q) * PROD_W'(num_q);
	assign div_ctl.divisor  = den_q;

	frim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q    <= RATIO_W'(1);
			den_q    <= RATIO_W'(1);
			linear_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATIO_NUM:   num_q <= cfg_data;
				REG_RATIO_DEN:   den_q <= cfg_data;
				REG_LINEAR_MODE: linear_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= '1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire && at_end) begin
						state_q <= ST_IDLE;
						last_q  <= {1'b0, src_q};
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= req.target_frame;
		end
		if ((state_q == ST_DIV) && div_stat.done) begin
			src_q <= div_stat.quot;
		end
		if (state_q == ST_CHECK) begin
			// Start just past the last fetched frame when skipped frames go out first.
			cur_q <= do_prefetch ? last_inc[FRAME_W-1:0] : src_q;
		end else if (emit_fire && !at_end) begin
			cur_q <= cur_q + FRAME_W'(1);
		end
		if (emit_fire) begin
			out_src_q  <= cur_q;
			out_pre_q  <= !at_end;
			out_last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (fetch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req.ready          = (state_q == ST_IDLE);
	assign fetch.valid        = out_valid_q;
	assign fetch.source_frame = out_src_q;
	assign fetch.is_prefetch  = out_pre_q;
	assign fetch.last_of_run  = out_last_q;

	`FRIM_ASSERT_IMP(a_prefetch_in_run, out_valid_q && out_pre_q, state_q == ST_EMIT)
	`FRIM_ASSERT_NEXT(a_last_updated, emit_fire && at_end, last_q == {1'b0, $past(src_q)})
	`FRIM_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV)
	`FRIM_ASSERT_IMP(a_div_busy_in_div, div_stat.busy, state_q == ST_DIV)
	`FRIM_ASSERT_IMP(a_cur_bounded, state_q == ST_EMIT, cur_q <= src_q)

endmodule
`default_nettype wire
